FILE: rtl/nearest_neighbor_image_resize_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest neighbor resize unit
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_IMAGE_RESIZE_UNIT_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_RESIZE_UNIT_ASSERT_SVH

// antecedent implies consequent in the next cycle, ignored during reset
`define NNR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("nnr assertion failed: next-cycle check");

// antecedent implies consequent in the same cycle, ignored during reset
`define NNR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("nnr assertion failed: same-cycle check");

// next-cycle check that stays live through reset
`define NNR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("nnr assertion failed: reset check");

`endif

FILE: rtl/nnr_pkg.sv
// ----------------------------------------------------------------------------
// nnr_pkg
// Sizes, widths, types and codes shared by the nearest neighbor resize unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nnr_pkg;

    // maximum frame sizes
    localparam int MAX_SRC_WIDTH  = 640;
    localparam int MAX_SRC_HEIGHT = 480;
    localparam int MAX_DST_WIDTH  = 640;
    localparam int MAX_DST_HEIGHT = 480;

    // register field widths
    localparam int SW_REG_W   = 10;
    localparam int SH_REG_W   = 9;
    localparam int DW_REG_W   = 10;
    localparam int DH_REG_W   = 9;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;

    // reset sizes
    localparam logic [SW_REG_W-1:0] RST_SRC_WIDTH  = SW_REG_W'(320);
    localparam logic [SH_REG_W-1:0] RST_SRC_HEIGHT = SH_REG_W'(240);
    localparam logic [DW_REG_W-1:0] RST_DST_WIDTH  = DW_REG_W'(320);
    localparam logic [DH_REG_W-1:0] RST_DST_HEIGHT = DH_REG_W'(240);

    // widths of clamped sizes and destination counters
    localparam int SW_W  = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SH_W  = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int DW_W  = $clog2(MAX_DST_WIDTH + 1);
    localparam int DH_W  = $clog2(MAX_DST_HEIGHT + 1);
    localparam int COL_W = DW_W;
    localparam int ROW_W = DH_W;

    // frame store
    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int FRAME_W     = $clog2(STORE_DEPTH + 1);

    // divider sizing: numerator 2*pos*s + d, denominator 2*d
    localparam int NUM_COL_MAX = 2 * (MAX_DST_WIDTH - 1) * MAX_SRC_WIDTH + MAX_DST_WIDTH;
    localparam int NUM_ROW_MAX = 2 * (MAX_DST_HEIGHT - 1) * MAX_SRC_HEIGHT + MAX_DST_HEIGHT;
    localparam int NUM_MAX     = (NUM_COL_MAX > NUM_ROW_MAX) ? NUM_COL_MAX : NUM_ROW_MAX;
    localparam int DST_MAX     = (MAX_DST_WIDTH > MAX_DST_HEIGHT) ? MAX_DST_WIDTH
                                                                  : MAX_DST_HEIGHT;
    localparam int DIV_NUM_W   = $clog2(NUM_MAX + 1);
    localparam int DIV_DEN_W   = $clog2(2 * DST_MAX + 1);
    localparam int DIV_CNT_W   = $clog2(DIV_NUM_W + 1);

    // input queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } t_cfg_idx;

    // item operation
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EMIT = 1'b1
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [PIX_W-1:0] pix;
    } t_item;

    // queue head seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    // clamped frame sizes
    typedef struct packed {
        logic [SW_W-1:0] sw;
        logic [SH_W-1:0] sh;
        logic [DW_W-1:0] dw;
        logic [DH_W-1:0] dh;
    } t_size;

endpackage

`default_nettype wire

FILE: rtl/nnr_ram.sv
// ----------------------------------------------------------------------------
// nnr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nnr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic                                         i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    output logic      [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port share one address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/nnr_div.sv
// ----------------------------------------------------------------------------
// nnr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nnr_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [nnr_pkg::DIV_NUM_W-1:0]  i_num,
    input  wire logic [nnr_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                                o_done,
    output logic      [nnr_pkg::DIV_NUM_W-1:0]  o_quo
);

    import nnr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_dq;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W+1:0] diff;
    logic                 q_bit;
    logic [DIV_DEN_W-1:0] n_rem;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        shifted = {r_rem, r_dq[DIV_NUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        q_bit   = ~diff[DIV_DEN_W+1];
        n_rem   = q_bit ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_dq  <= {r_dq[DIV_NUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_dq;

endmodule

`default_nettype wire

FILE: rtl/nnr_front.sv
// ----------------------------------------------------------------------------
// nnr_front
// Accepts items, classifies the command and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module nnr_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_command,
    input  wire logic [nnr_pkg::CH_W-1:0]   i_red_in,
    input  wire logic [nnr_pkg::CH_W-1:0]   i_green_in,
    input  wire logic [nnr_pkg::CH_W-1:0]   i_blue_in,
    output nnr_pkg::t_qhead                 o_head,
    input  wire logic                       i_pop
);

    import nnr_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_cnt;

    logic  push;
    logic  pop;
    t_item in_item;

    // classify the incoming item
    always_comb begin
        in_item.op  = t_op'(i_command);
        in_item.pix = {i_red_in, i_green_in, i_blue_in};
    end

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_cnt != '0);

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= in_item;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_mem[r_rp];

endmodule

`default_nettype wire

FILE: rtl/nnr_back.sv
// ----------------------------------------------------------------------------
// nnr_back
// Executes queued items: frame store writes on load, index mapping and
// frame store reads on emit, with an output register toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module nnr_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire nnr_pkg::t_size             i_size,
    input  wire nnr_pkg::t_qhead            i_head,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [nnr_pkg::CH_W-1:0]   o_red_out,
    output logic      [nnr_pkg::CH_W-1:0]   o_green_out,
    output logic      [nnr_pkg::CH_W-1:0]   o_blue_out,
    output logic                            o_frame_last
);

    import nnr_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_LD_MUL   = 10'b00_0000_0010,
        S_LD_WR    = 10'b00_0000_0100,
        S_EM_WRAP  = 10'b00_0000_1000,
        S_EM_MUL   = 10'b00_0001_0000,
        S_EM_START = 10'b00_0010_0000,
        S_EM_DIV   = 10'b00_0100_0000,
        S_EM_MAP   = 10'b00_1000_0000,
        S_EM_RD    = 10'b01_0000_0000,
        S_EM_OUT   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // architectural counters
    logic [FRAME_W-1:0] r_lpos;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;

    // working registers
    logic [PIX_W-1:0]       r_pix;
    logic [FRAME_W-1:0]     r_frame;
    logic [ROW_W+SH_W-1:0]  r_prod_row;
    logic [COL_W+SW_W-1:0]  r_prod_col;
    logic [FRAME_W-1:0]     r_row_base;
    logic [SW_W-1:0]        r_col_idx;
    logic                   r_last;

    // output register
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_out_pix;
    logic               r_out_last;

    // divider hookup
    logic                  div_start;
    logic [DIV_NUM_W-1:0]  num_row;
    logic [DIV_NUM_W-1:0]  num_col;
    logic [DIV_DEN_W-1:0]  den_row;
    logic [DIV_DEN_W-1:0]  den_col;
    logic                  done_row;
    logic                  done_col;
    logic [DIV_NUM_W-1:0]  quo_row;
    logic [DIV_NUM_W-1:0]  quo_col;

    // combinational helpers
    logic [SW_W+SH_W-1:0]  frame_prod;
    logic [FRAME_W-1:0]    ld_pos;
    logic [FRAME_W-1:0]    ld_next;
    logic [SH_W-1:0]       row_idx;
    logic [SW_W-1:0]       col_idx;
    logic [SH_W+SW_W-1:0]  base_prod;
    logic [FRAME_W-1:0]    rd_addr;
    logic [COL_W:0]        col_inc;
    logic                  out_free;

    // frame store
    logic                  ram_we;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_addr;
    logic [PIX_W-1:0]      ram_rdata;

    assign out_free = !r_out_valid || i_ready;

    // load address: restart at zero when the position is past the frame
    always_comb begin
        frame_prod = i_size.sw * i_size.sh;
        ld_pos     = (r_lpos >= r_frame) ? '0 : r_lpos;
        ld_next    = ld_pos + 1'b1;
    end

    // mapping numerators and denominators
    always_comb begin
        num_row = (DIV_NUM_W'(r_prod_row) << 1) + DIV_NUM_W'(i_size.dh);
        num_col = (DIV_NUM_W'(r_prod_col) << 1) + DIV_NUM_W'(i_size.dw);
        den_row = DIV_DEN_W'({i_size.dh, 1'b0});
        den_col = DIV_DEN_W'({i_size.dw, 1'b0});
    end

    // clamp quotients to the last source row and column
    always_comb begin
        row_idx   = (quo_row >= DIV_NUM_W'(i_size.sh)) ? i_size.sh - SH_W'(1)
                                                       : SH_W'(quo_row);
        col_idx   = (quo_col >= DIV_NUM_W'(i_size.sw)) ? i_size.sw - SW_W'(1)
                                                       : SW_W'(quo_col);
        base_prod = row_idx * i_size.sw;
        rd_addr   = r_row_base + FRAME_W'(r_col_idx);
        col_inc   = {1'b0, r_col} + 1'b1;
    end

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        div_start = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = ld_pos[ADDR_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_state = (i_head.item.op == OP_EMIT) ? S_EM_WRAP : S_LD_MUL;
                end
            end
            S_LD_MUL:   n_state = S_LD_WR;
            S_LD_WR: begin
                ram_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_EM_WRAP:  n_state = S_EM_MUL;
            S_EM_MUL:   n_state = S_EM_START;
            S_EM_START: begin
                div_start = 1'b1;
                n_state   = S_EM_DIV;
            end
            S_EM_DIV: begin
                if (done_row && done_col) begin
                    n_state = S_EM_MAP;
                end
            end
            S_EM_MAP:   n_state = S_EM_RD;
            S_EM_RD: begin
                ram_re   = 1'b1;
                ram_addr = rd_addr[ADDR_W-1:0];
                n_state  = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lpos      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == S_LD_WR) begin
                r_lpos <= (ld_next >= r_frame) ? '0 : ld_next;
            end

            // wrap counters left past a shrunk destination size
            if (r_state == S_EM_WRAP) begin
                if (r_col >= i_size.dw) begin
                    r_col <= '0;
                    r_row <= ((r_row + 1'b1) >= i_size.dh) ? '0 : r_row + 1'b1;
                end else if (r_row >= i_size.dh) begin
                    r_row <= '0;
                end
            end

            // step to the next destination pixel
            if (r_state == S_EM_RD) begin
                if (col_inc >= (COL_W+1)'(i_size.dw)) begin
                    r_col <= '0;
                    r_row <= ((r_row + 1'b1) >= i_size.dh) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= col_inc[COL_W-1:0];
                end
            end

            if ((r_state == S_EM_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pix <= i_head.item.pix;
        end
        if (r_state == S_LD_MUL) begin
            r_frame <= FRAME_W'(frame_prod);
        end
        if (r_state == S_EM_MUL) begin
            r_prod_row <= r_row * i_size.sh;
            r_prod_col <= r_col * i_size.sw;
        end
        if (r_state == S_EM_MAP) begin
            r_row_base <= FRAME_W'(base_prod);
            r_col_idx  <= col_idx;
        end
        if (r_state == S_EM_RD) begin
            r_last <= (r_row == i_size.dh - DH_W'(1)) && (r_col == i_size.dw - DW_W'(1));
        end
        if ((r_state == S_EM_OUT) && out_free) begin
            r_out_pix  <= ram_rdata;
            r_out_last <= r_last;
        end
    end

    nnr_div u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_row),
        .i_den   (den_row),
        .o_done  (done_row),
        .o_quo   (quo_row)
    );

    nnr_div u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_col),
        .i_den   (den_col),
        .o_done  (done_col),
        .o_quo   (quo_col)
    );

    nnr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (r_pix),
        .o_rdata (ram_rdata)
    );

    assign o_valid      = r_out_valid;
    assign o_red_out    = r_out_pix[3*CH_W-1:2*CH_W];
    assign o_green_out  = r_out_pix[2*CH_W-1:CH_W];
    assign o_blue_out   = r_out_pix[CH_W-1:0];
    assign o_frame_last = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/nearest_neighbor_image_resize_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_resize_unit
// Nearest neighbor RGB frame scaler: load source pixels, emit resized pixels.
// ----------------------------------------------------------------------------
// Items enter a two-entry queue and are executed one at a time. A load item
// passes through the frame size multiply and then the frame store write in
// the execution stage. For an emit item the source row and column are found
// by two restoring dividers running side by side at one quotient bit per
// cycle, followed by the address multiply and the registered frame store
// read. The input queue keeps taking items, until its two entries are full,
// while the execution stage works or the output register waits on the
// consumer. The frame store has no reset; emit only after the source pixels
// it maps to were loaded. Size registers written as zero act as 1, and sizes
// above the maximum act as the maximum.
`default_nettype none

module nearest_neighbor_image_resize_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [nnr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [nnr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic                               i_command,
    input  wire logic [nnr_pkg::CH_W-1:0]           i_red_in,
    input  wire logic [nnr_pkg::CH_W-1:0]           i_green_in,
    input  wire logic [nnr_pkg::CH_W-1:0]           i_blue_in,
    // result items
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic      [nnr_pkg::CH_W-1:0]           o_red_out,
    output logic      [nnr_pkg::CH_W-1:0]           o_green_out,
    output logic      [nnr_pkg::CH_W-1:0]           o_blue_out,
    output logic                                    o_frame_last
);

    import nnr_pkg::*;

    logic [SW_REG_W-1:0] r_src_width;
    logic [SH_REG_W-1:0] r_src_height;
    logic [DW_REG_W-1:0] r_dst_width;
    logic [DH_REG_W-1:0] r_dst_height;

    t_size  size;
    t_qhead head;
    logic   pop;

    // size clamps: zero acts as one, oversize acts as the maximum
    function automatic logic [SW_W-1:0] clamp_sw(input logic [SW_REG_W-1:0] v);
        logic [SW_W-1:0] res;
        if (v == '0) begin
            res = SW_W'(1);
        end else if (v > MAX_SRC_WIDTH) begin
            res = SW_W'(MAX_SRC_WIDTH);
        end else begin
            res = SW_W'(v);
        end
        return res;
    endfunction

    function automatic logic [SH_W-1:0] clamp_sh(input logic [SH_REG_W-1:0] v);
        logic [SH_W-1:0] res;
        if (v == '0) begin
            res = SH_W'(1);
        end else if (v > MAX_SRC_HEIGHT) begin
            res = SH_W'(MAX_SRC_HEIGHT);
        end else begin
            res = SH_W'(v);
        end
        return res;
    endfunction

    function automatic logic [DW_W-1:0] clamp_dw(input logic [DW_REG_W-1:0] v);
        logic [DW_W-1:0] res;
        if (v == '0) begin
            res = DW_W'(1);
        end else if (v > MAX_DST_WIDTH) begin
            res = DW_W'(MAX_DST_WIDTH);
        end else begin
            res = DW_W'(v);
        end
        return res;
    endfunction

    function automatic logic [DH_W-1:0] clamp_dh(input logic [DH_REG_W-1:0] v);
        logic [DH_W-1:0] res;
        if (v == '0) begin
            res = DH_W'(1);
        end else if (v > MAX_DST_HEIGHT) begin
            res = DH_W'(MAX_DST_HEIGHT);
        end else begin
            res = DH_W'(v);
        end
        return res;
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= RST_SRC_WIDTH;
            r_src_height <= RST_SRC_HEIGHT;
            r_dst_width  <= RST_DST_WIDTH;
            r_dst_height <= RST_DST_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[SW_REG_W-1:0];
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[SH_REG_W-1:0];
                CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data[DW_REG_W-1:0];
                CFG_DST_HEIGHT: r_dst_height <= i_cfg_data[DH_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        size.sw = clamp_sw(r_src_width);
        size.sh = clamp_sh(r_src_height);
        size.dw = clamp_dw(r_dst_width);
        size.dh = clamp_dh(r_dst_height);
    end

    nnr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_red_in   (i_red_in),
        .i_green_in (i_green_in),
        .i_blue_in  (i_blue_in),
        .o_head     (head),
        .i_pop      (pop)
    );

    nnr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_size       (size),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_frame_last (o_frame_last)
    );

endmodule

`default_nettype wire

FILE: rtl/nnr_checker.sv
// ----------------------------------------------------------------------------
// nnr_checker
// Port-level checks for the nearest neighbor resize unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_neighbor_image_resize_unit_assert.svh"

module nnr_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      o_ready,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic [nnr_pkg::CH_W-1:0]  o_red_out,
    input wire logic [nnr_pkg::CH_W-1:0]  o_green_out,
    input wire logic [nnr_pkg::CH_W-1:0]  o_blue_out,
    input wire logic                      o_frame_last
);

    // reset empties the output register and the input queue
    `NNR_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_valid && o_ready)

    // a stalled result stays offered
    `NNR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

    // a stalled result keeps its payload
    `NNR_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable({o_red_out, o_green_out, o_blue_out, o_frame_last}))

    // the queue only fills through accepted items
    `NNR_ASSERT_SAME(a_full_after_accept, i_clk, i_rst_n, $fell(o_ready), $past(i_valid && o_ready))

endmodule

bind nearest_neighbor_image_resize_unit nnr_checker u_nnr_checker (.*);

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the nearest neighbor resize unit by driving load and emit items
// through its valid/ready ports. A behavioral scaler inside the bench tracks
// the frame store, the load and emit counters and the size registers, and
// every emitted pixel is compared against it or a value typed in the table.
// A short table of hand-picked items comes first; planned and random size
// settings with random pixel data follow, under several idle and stall patterns.
// ----------------------------------------------------------------------------

module testbench;

    import nnr_pkg::*;

    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 40;   // > emit latency plus a full queue of loads
    localparam int HOLD_CYCLES   = 400;  // long consumer hold-off
    localparam int HOLD_BURST    = 12;   // emits pushed while the consumer holds off
    localparam int HOLD_PHASE    = 6;
    localparam int PAUSE_PHASE   = 3;
    localparam int N_DIR         = 30;
    localparam int N_PLAN        = 12;
    localparam int N_RAND_PLAN   = 4;
    localparam int RAND_ITEMS    = 20;

    // one destination pixel as it leaves the block
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } t_pix_result;

    typedef enum logic { ROW_CFG, ROW_ITEM } t_row_kind;

    // one row of the directed table
    typedef struct packed {
        t_row_kind           kind;
        t_cfg_idx            idx;
        logic [CFG_DATA_W-1:0] value;
        t_op                 op;
        logic [PIX_W-1:0]    pix;
        logic                typed;
        t_pix_result         res;
    } t_dir_row;

    // ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    t_cfg_idx              i_cfg_index = CFG_SRC_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    logic                  i_command   = OP_LOAD;
    logic [CH_W-1:0]       i_red_in    = '0;
    logic [CH_W-1:0]       i_green_in  = '0;
    logic [CH_W-1:0]       i_blue_in   = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic [CH_W-1:0]       o_red_out;
    logic [CH_W-1:0]       o_green_out;
    logic [CH_W-1:0]       o_blue_out;
    logic                  o_frame_last;

    // scaler state mirrored by the bench
    logic [PIX_W-1:0]    pix_store   [STORE_DEPTH];
    bit                  pix_written [STORE_DEPTH];
    int unsigned         load_pos = 0;
    int unsigned         out_col  = 0;
    int unsigned         out_row  = 0;
    logic [SW_REG_W-1:0] reg_src_w = RST_SRC_WIDTH;
    logic [SH_REG_W-1:0] reg_src_h = RST_SRC_HEIGHT;
    logic [DW_REG_W-1:0] reg_dst_w = RST_DST_WIDTH;
    logic [DH_REG_W-1:0] reg_dst_h = RST_DST_HEIGHT;

    t_pix_result pix_expect_q [$];

    // idle control
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int send_idle_by_mode  [4] = '{0, 85, 0, 27};
    int recv_stall_by_mode [4] = '{0, 0, 85, 27};

    // run statistics
    int fail_count     = 0;
    int items_sent     = 0;
    int emits_sent     = 0;
    int pixels_checked = 0;
    int frame_ends     = 0;
    int settings_run   = 0;

    t_dir_row dir_rows [N_DIR];

    // source width, source height, target width, target height
    logic [CFG_DATA_W-1:0] size_plan [N_PLAN][4] = '{
        '{10'd640,  10'd1,   10'd1023, 10'd1},
        '{10'd1,    10'd511, 10'd1,    10'd480},
        '{10'd4,    10'd3,   10'd7,    10'd5},
        '{10'd3,    10'd4,   10'd2,    10'd2},
        '{10'd0,    10'd0,   10'd5,    10'd3},
        '{10'd8,    10'd6,   10'd8,    10'd6},
        '{10'd5,    10'd5,   10'd11,   10'd9},
        '{10'd1,    10'd480, 10'd1,    10'd13},
        '{10'd6,    10'd2,   10'd12,   10'd1},
        '{10'd1023, 10'd0,   10'd640,  10'd0},
        '{10'd7,    10'd3,   10'd3,    10'd7},
        '{10'd1,    10'd1,   10'd1,    10'd1}
    };
    // random items per planned setting
    int plan_items [N_PLAN] = '{20, 30, 40, 30, 20, 40, 40, 30, 30, 20, 40, 20};

    nearest_neighbor_image_resize_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_frame_last (o_frame_last)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // scaler prediction
    // ------------------------------------------------------------------------
    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // nearest source index, halves rounded up, clamped to the source size
    function automatic int unsigned nearest_src(input int unsigned pos, input int unsigned s,
                                                input int unsigned d);
        int unsigned q;
        q = (2 * pos * s + d) / (2 * d);
        return (q >= s) ? s - 1 : q;
    endfunction

    // applies one item to the mirrored state; returns 1 when it emits a pixel
    function automatic bit resize_step(input t_op op, input logic [PIX_W-1:0] pix,
                                       output t_pix_result res);
        int unsigned sw, sh, dw, dh, frame, addr;
        sw    = clamp_size(reg_src_w, MAX_SRC_WIDTH);
        sh    = clamp_size(reg_src_h, MAX_SRC_HEIGHT);
        dw    = clamp_size(reg_dst_w, MAX_DST_WIDTH);
        dh    = clamp_size(reg_dst_h, MAX_DST_HEIGHT);
        frame = sw * sh;
        res   = '0;
        if (op == OP_LOAD) begin
            // a position left beyond a shrunken frame restarts at 0
            if (load_pos >= frame) load_pos = 0;
            pix_store[load_pos]   = pix;
            pix_written[load_pos] = 1'b1;
            load_pos++;
            if (load_pos >= frame) load_pos = 0;
            return 1'b0;
        end
        // counters left beyond a shrunken target move on first
        if (out_col >= dw) begin
            out_col = 0;
            out_row++;
        end
        if (out_row >= dh) out_row = 0;
        addr      = nearest_src(out_row, sh, dh) * sw + nearest_src(out_col, sw, dw);
        res.red   = pix_store[addr][23:16];
        res.green = pix_store[addr][15:8];
        res.blue  = pix_store[addr][7:0];
        res.last  = (out_row == dh - 1) && (out_col == dw - 1);
        out_col++;
        if (out_col >= dw) begin
            out_col = 0;
            out_row++;
            if (out_row >= dh) out_row = 0;
        end
        return 1'b1;
    endfunction

    // every entry of the current source frame has been loaded at least once
    function automatic bit frame_loaded();
        int unsigned frame;
        frame = clamp_size(reg_src_w, MAX_SRC_WIDTH) * clamp_size(reg_src_h, MAX_SRC_HEIGHT);
        for (int unsigned a = 0; a < frame; a++)
            if (!pix_written[a]) return 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // table row builders
    // ------------------------------------------------------------------------
    function automatic t_dir_row cfg_row(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] v);
        t_dir_row r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.value = v;
        return r;
    endfunction

    function automatic t_dir_row load_row(input logic [PIX_W-1:0] pix);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.op   = OP_LOAD;
        r.pix  = pix;
        return r;
    endfunction

    // typed = 0: the expectation comes from the predictor
    function automatic t_dir_row emit_row(input bit typed, input logic [PIX_W-1:0] pix,
                                          input bit last);
        t_dir_row r;
        r       = '0;
        r.kind  = ROW_ITEM;
        r.op    = OP_EMIT;
        r.typed = typed;
        r.res   = {pix, last};
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // driving tasks (called at a rising edge, return at a rising edge)
    // ------------------------------------------------------------------------
    task automatic send_item(input t_op op, input logic [PIX_W-1:0] pix, input bit typed,
                             input t_pix_result typed_res, input bit may_idle);
        t_pix_result res;
        if (may_idle && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid   <= 1'b1;
        i_command <= op;
        {i_red_in, i_green_in, i_blue_in} <= pix;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (resize_step(op, pix, res)) begin
            pix_expect_q.push_back(typed ? typed_res : res);
            emits_sent++;
        end
    endtask

    // stop sending, let every expected pixel arrive and trailing loads retire
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pix_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_SRC_WIDTH:  reg_src_w = v[SW_REG_W-1:0];
            CFG_SRC_HEIGHT: reg_src_h = v[SH_REG_W-1:0];
            CFG_DST_WIDTH:  reg_dst_w = v[DW_REG_W-1:0];
            CFG_DST_HEIGHT: reg_dst_h = v[DH_REG_W-1:0];
            default: ;
        endcase
    endtask

    // one size setting: program it, fill the source frame, then random items
    task automatic run_phase(input int ph, input logic [CFG_DATA_W-1:0] sw,
                             input logic [CFG_DATA_W-1:0] sh, input logic [CFG_DATA_W-1:0] dw,
                             input logic [CFG_DATA_W-1:0] dh, input int n_items);
        t_op op;
        wait_idle();
        send_idle_pct  = send_idle_by_mode[ph % 4];
        recv_stall_pct <= recv_stall_by_mode[ph % 4];
        write_size_reg(CFG_SRC_WIDTH, sw);
        write_size_reg(CFG_SRC_HEIGHT, sh);
        write_size_reg(CFG_DST_WIDTH, dw);
        write_size_reg(CFG_DST_HEIGHT, dh);
        settings_run++;
        // raster fill until every source entry holds data
        while (!frame_loaded())
            send_item(OP_LOAD, PIX_W'($urandom), 1'b0, '0, 1'b1);
        for (int k = 0; k < n_items; k++) begin
            if (ph == PAUSE_PHASE && k == n_items / 2) wait_idle();
            if (ph == HOLD_PHASE && k == 0) hold_requests <= hold_requests + 1;
            if (ph == HOLD_PHASE && k < HOLD_BURST) begin
                // back-to-back emits while the consumer holds off
                send_item(OP_EMIT, PIX_W'($urandom), 1'b0, '0, 1'b0);
            end else begin
                op = ($urandom_range(99) < 60) ? OP_EMIT : OP_LOAD;
                send_item(op, PIX_W'($urandom), 1'b0, '0, 1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // consumer ready: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pix_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pix_expect_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected pixel r=%h g=%h b=%h last=%b", $realtime,
                             o_red_out, o_green_out, o_blue_out, o_frame_last);
            end else begin
                want = pix_expect_q.pop_front();
                pixels_checked++;
                if (o_frame_last) frame_ends++;
                if (o_red_out !== want.red || o_green_out !== want.green ||
                    o_blue_out !== want.blue || o_frame_last !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"%0t: pixel mismatch: expected r=%h g=%h b=%h last=%b,",
                                  " got r=%h g=%h b=%h last=%b"},
                                 $realtime, want.red, want.green, want.blue, want.last,
                                 o_red_out, o_green_out, o_blue_out, o_frame_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_DATA_W-1:0] rsw, rsh, rdw, rdh;
        dir_rows = '{
            // all sizes zero act as a 1x1 frame
            cfg_row(CFG_SRC_WIDTH, 10'd0),
            cfg_row(CFG_SRC_HEIGHT, 10'd0),
            cfg_row(CFG_DST_WIDTH, 10'd0),
            cfg_row(CFG_DST_HEIGHT, 10'd0),
            load_row(24'hFF00FF),
            emit_row(1'b1, 24'hFF00FF, 1'b1),
            // second load wraps back onto entry 0
            load_row(24'h00FF00),
            emit_row(1'b1, 24'h00FF00, 1'b1),
            // two-wide target: both columns hit the only source pixel
            cfg_row(CFG_DST_WIDTH, 10'd2),
            emit_row(1'b1, 24'h00FF00, 1'b0),
            emit_row(1'b1, 24'h00FF00, 1'b1),
            emit_row(1'b1, 24'h00FF00, 1'b0),
            // target shrunk under the column counter
            cfg_row(CFG_DST_WIDTH, 10'd1),
            emit_row(1'b1, 24'h00FF00, 1'b1),
            // 2x1 source at the same size
            cfg_row(CFG_SRC_WIDTH, 10'd2),
            load_row(24'h123456),
            load_row(24'hABCDEF),
            cfg_row(CFG_DST_WIDTH, 10'd2),
            emit_row(1'b1, 24'h123456, 1'b0),
            emit_row(1'b1, 24'hABCDEF, 1'b1),
            // upscale 2 -> 3 columns
            cfg_row(CFG_DST_WIDTH, 10'd3),
            emit_row(1'b0, 24'h0, 1'b0),
            emit_row(1'b0, 24'h0, 1'b0),
            emit_row(1'b0, 24'h0, 1'b0),
            // source shrunk under the load position
            load_row(24'h000000),
            cfg_row(CFG_SRC_WIDTH, 10'd0),
            load_row(24'hFFFFFF),
            emit_row(1'b0, 24'h0, 1'b0),
            // upper data bit is outside the height register
            cfg_row(CFG_DST_HEIGHT, 10'd1023),
            emit_row(1'b0, 24'h0, 1'b0)
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, no idling
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_size_reg(dir_rows[i].idx, dir_rows[i].value);
            end else begin
                send_item(dir_rows[i].op, dir_rows[i].pix, dir_rows[i].typed,
                          dir_rows[i].res, 1'b0);
            end
        end

        // planned size settings, extremes among them
        for (int p = 0; p < N_PLAN; p++)
            run_phase(p, size_plan[p][0], size_plan[p][1], size_plan[p][2],
                      size_plan[p][3], plan_items[p]);

        // random small sizes, zero included
        for (int p = 0; p < N_RAND_PLAN; p++) begin
            rsw = $urandom_range(9);
            rsh = $urandom_range(7);
            rdw = $urandom_range(12);
            rdh = $urandom_range(9);
            run_phase(N_PLAN + p, rsw, rsh, rdw, rdh, RAND_ITEMS);
        end

        wait_idle();
        $display("summary: %0d items (%0d emits) over %0d size settings", items_sent,
                 emits_sent, settings_run);
        $display("summary: %0d pixels checked, %0d frame ends, %0d failures", pixels_checked,
                 frame_ends, fail_count);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("timeout with %0d pixels outstanding", pix_expect_q.size());
        $display("testbench: FAIL");
        $finish;
    end

endmodule
